// ===== rtl/tdpl_pkg.sv =====
package tdpl_pkg;

  localparam int unsigned DefValueWidth   = 16;
  localparam int unsigned DefMaxPrimes    = 64;
  localparam int unsigned MinCandWidth    = 10;
  localparam int unsigned PrimeValueWidth = 15;
  localparam int unsigned IndexWidth      = 6;
  localparam int unsigned StatusWidth     = 3;
  localparam int unsigned CountWidth      = 7;

  typedef enum logic [StatusWidth-1:0] {
    StOk        = 3'd0,
    StFirstBad  = 3'd1,
    StSecondBad = 3'd2,
    StBothBad   = 3'd3,
    StNone      = 3'd4,
    StTruncated = 3'd5
  } status_e;

  typedef struct packed {
    logic [PrimeValueWidth-1:0] prime_value;
    logic [IndexWidth-1:0]      prime_index;
    status_e                    status;
    logic                       last;
  } result_t;

endpackage

// ===== rtl/tdpl_if.sv =====
interface tdpl_req_if #(
  parameter int unsigned VALUE_WIDTH = tdpl_pkg::DefValueWidth
) ();
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [VALUE_WIDTH-1:0] first_value;
  logic signed [VALUE_WIDTH-1:0] second_value;

  modport source (output valid, output mode, output first_value, output second_value,
                  input ready);
  modport sink (input valid, input mode, input first_value, input second_value,
                output ready);
endinterface

interface tdpl_res_if ();
  logic                                      valid;
  logic                                      ready;
  logic [tdpl_pkg::PrimeValueWidth-1:0]      prime_value;
  logic [tdpl_pkg::IndexWidth-1:0]           prime_index;
  logic [tdpl_pkg::StatusWidth-1:0]          status;
  logic                                      last;

  modport source (output valid, output prime_value, output prime_index, output status,
                  output last, input ready);
  modport sink (input valid, input prime_value, input prime_index, input status,
                input last, output ready);
endinterface

// ===== rtl/tdpl_rem_unit.sv =====
module tdpl_rem_unit #(
  parameter int unsigned WIDTH = tdpl_pkg::MinCandWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] rem_o
);

  localparam int unsigned CntWidth = $clog2(WIDTH) + 1;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic [WIDTH-1:0]    remainder_work_q, remainder_work_d;
  logic [WIDTH-1:0]    shift_q, shift_d;
  logic [WIDTH:0]      trial;
  logic [WIDTH:0]      diff;

  assign trial = {remainder_work_q, shift_q[WIDTH-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d           = busy_q;
    done_d           = 1'b0;
    count_d          = count_q;
    remainder_work_d = remainder_work_q;
    shift_d          = shift_q;
    if (start_i) begin
      busy_d           = 1'b1;
      count_d          = CntWidth'(WIDTH);
      remainder_work_d = '0;
      shift_d          = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        remainder_work_d = diff[WIDTH-1:0];
      end else begin
        remainder_work_d = trial[WIDTH-1:0];
      end
      shift_d = {shift_q[WIDTH-2:0], 1'b0};
      count_d = count_q - CntWidth'(1);
      if (count_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    remainder_work_q <= remainder_work_d;
    shift_q          <= shift_d;
  end

  assign done_o = done_q;
  assign rem_o  = remainder_work_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("remainder unit restarted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done_o && divisor_i != '0 |-> rem_o < divisor_i)
    else $error("remainder not below divisor");

endmodule

// ===== rtl/tdpl_out_reg.sv =====
module tdpl_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tdpl_pkg::result_t data_i,
  output logic              ready_o,
  tdpl_res_if.source        res_o
);

  logic              valid_q, valid_d;
  tdpl_pkg::result_t data_q;

  assign ready_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (res_o.ready) begin
      valid_d = 1'b0;
    end
    if (push_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign res_o.valid       = valid_q;
  assign res_o.prime_value = data_q.prime_value;
  assign res_o.prime_index = data_q.prime_index;
  assign res_o.status      = data_q.status;
  assign res_o.last        = data_q.last;

endmodule

// ===== rtl/trial_division_prime_lister_unit.sv =====
// channel  dir  modport           word
// req_i    in   tdpl_req_if.sink  mode, first_value, second_value
// res_o    out  tdpl_res_if.source prime_value, prime_index, status, last
//
// One request at a time; req_i.ready is high only while idle.
// Each trial divisor is tested by the bit-serial remainder unit, which is CandWidth bits wide,
// CandWidth = max(VALUE_WIDTH, 10); candidates are tested one after another.
// Error results go from the idle phase into em_q and then into the output register.
// Reset clears the sequencer and the output valid; data registers are not reset.
// A stalled res_o holds the sequencer at the next result word.
module trial_division_prime_lister_unit #(
  parameter int unsigned VALUE_WIDTH = tdpl_pkg::DefValueWidth,
  parameter int unsigned MAX_PRIMES  = tdpl_pkg::DefMaxPrimes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tdpl_req_if.sink    req_i,
  tdpl_res_if.source  res_o
);

  localparam int unsigned CandWidth = (VALUE_WIDTH > tdpl_pkg::MinCandWidth) ?
                                      VALUE_WIDTH : tdpl_pkg::MinCandWidth;
  localparam int unsigned CntW      = tdpl_pkg::CountWidth;

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhTest  = 3'd1;
  localparam logic [2:0] PhCheck = 3'd2;
  localparam logic [2:0] PhDiv   = 3'd3;
  localparam logic [2:0] PhEmit  = 3'd4;

  logic [2:0]           busy_phase_q, busy_phase_d;
  logic                 mode_q, mode_d;
  logic [CandWidth-1:0] candidate_q, candidate_d;
  logic [CandWidth-1:0] upper_q, upper_d;
  logic [CandWidth-1:0] divisor_q, divisor_d;
  logic [CandWidth:0]   dsq_q, dsq_d;
  logic [CntW-1:0]      found_count_q, found_count_d;
  logic [CntW-1:0]      target_q, target_d;
  logic                 trunc_q, trunc_d;
  logic                 pend_valid_q, pend_valid_d;
  logic [CandWidth-1:0] pend_value_q, pend_value_d;
  tdpl_pkg::result_t    em_q, em_d;

  logic [VALUE_WIDTH-1:0] a_u, b_u;
  logic                   a_bad, b_bad;
  logic [CandWidth-1:0]   a_ext, b_ext;
  logic [CntW-1:0]        cnt_inc;
  logic                   req_fire;
  logic                   div_start, div_done;
  logic [CandWidth-1:0]   div_rem;
  logic                   push, out_ready;

  assign a_u      = req_i.first_value;
  assign b_u      = req_i.second_value;
  assign a_bad    = a_u[VALUE_WIDTH-1] || (a_u == '0);
  assign b_bad    = b_u[VALUE_WIDTH-1] || (b_u == '0);
  assign a_ext    = CandWidth'(a_u);
  assign b_ext    = CandWidth'(b_u);
  assign cnt_inc  = found_count_q + CntW'(1);
  assign req_fire = req_i.valid && req_i.ready;
  assign req_i.ready = (busy_phase_q == PhIdle);

  always_comb begin
    busy_phase_d  = busy_phase_q;
    mode_d        = mode_q;
    candidate_d   = candidate_q;
    upper_d       = upper_q;
    divisor_d     = divisor_q;
    dsq_d         = dsq_q;
    found_count_d = found_count_q;
    target_d      = target_q;
    trunc_d       = trunc_q;
    pend_valid_d  = pend_valid_q;
    pend_value_d  = pend_value_q;
    em_d          = em_q;
    div_start     = 1'b0;
    push          = 1'b0;
    unique case (busy_phase_q)
      PhIdle: begin
        if (req_fire) begin
          mode_d        = req_i.mode;
          found_count_d = '0;
          pend_valid_d  = 1'b0;
          if (!req_i.mode) begin
            if (a_bad) begin
              em_d         = '{'0, '0, tdpl_pkg::StFirstBad, 1'b1};
              busy_phase_d = PhEmit;
            end else begin
              trunc_d      = a_ext > CandWidth'(MAX_PRIMES);
              target_d     = (a_ext > CandWidth'(MAX_PRIMES)) ? CntW'(MAX_PRIMES) : CntW'(a_ext);
              candidate_d  = CandWidth'(2);
              busy_phase_d = PhTest;
            end
          end else if (a_bad || b_bad) begin
            em_d = '{'0, '0, (a_bad && b_bad) ? tdpl_pkg::StBothBad :
                             (a_bad ? tdpl_pkg::StFirstBad : tdpl_pkg::StSecondBad), 1'b1};
            busy_phase_d = PhEmit;
          end else begin
            candidate_d  = (a_ext <= b_ext) ? a_ext : b_ext;
            upper_d      = (a_ext <= b_ext) ? b_ext : a_ext;
            busy_phase_d = PhTest;
          end
        end
      end
      PhTest: begin
        if (mode_q && candidate_q >= upper_q) begin
          if (pend_valid_q) begin
            em_d = '{tdpl_pkg::PrimeValueWidth'(pend_value_q),
                     tdpl_pkg::IndexWidth'(found_count_q - CntW'(1)),
                     tdpl_pkg::StOk, 1'b1};
          end else begin
            em_d = '{'0, '0, tdpl_pkg::StNone, 1'b1};
          end
          busy_phase_d = PhEmit;
        end else if (candidate_q < CandWidth'(2)) begin
          candidate_d = candidate_q + CandWidth'(1);
        end else begin
          divisor_d    = CandWidth'(2);
          dsq_d        = (CandWidth + 1)'(4);
          busy_phase_d = PhCheck;
        end
      end
      PhCheck: begin
        if (dsq_q > {1'b0, candidate_q}) begin
          if (!mode_q) begin
            em_d = '{tdpl_pkg::PrimeValueWidth'(candidate_q),
                     tdpl_pkg::IndexWidth'(found_count_q),
                     (cnt_inc == target_q && trunc_q) ? tdpl_pkg::StTruncated : tdpl_pkg::StOk,
                     cnt_inc == target_q};
            found_count_d = cnt_inc;
            busy_phase_d  = PhEmit;
          end else if (!pend_valid_q) begin
            pend_valid_d  = 1'b1;
            pend_value_d  = candidate_q;
            found_count_d = CntW'(1);
            candidate_d   = candidate_q + CandWidth'(1);
            busy_phase_d  = PhTest;
          end else if (found_count_q == CntW'(MAX_PRIMES)) begin
            em_d = '{tdpl_pkg::PrimeValueWidth'(pend_value_q),
                     tdpl_pkg::IndexWidth'(found_count_q - CntW'(1)),
                     tdpl_pkg::StTruncated, 1'b1};
            busy_phase_d = PhEmit;
          end else begin
            em_d = '{tdpl_pkg::PrimeValueWidth'(pend_value_q),
                     tdpl_pkg::IndexWidth'(found_count_q - CntW'(1)),
                     tdpl_pkg::StOk, 1'b0};
            pend_value_d  = candidate_q;
            found_count_d = cnt_inc;
            busy_phase_d  = PhEmit;
          end
        end else begin
          div_start    = 1'b1;
          busy_phase_d = PhDiv;
        end
      end
      PhDiv: begin
        if (div_done) begin
          if (div_rem == '0) begin
            candidate_d  = candidate_q + CandWidth'(1);
            busy_phase_d = PhTest;
          end else begin
            divisor_d    = divisor_q + CandWidth'(1);
            dsq_d        = dsq_q + {divisor_q, 1'b1};
            busy_phase_d = PhCheck;
          end
        end
      end
      PhEmit: begin
        if (out_ready) begin
          push = 1'b1;
          if (em_q.last) begin
            busy_phase_d = PhIdle;
          end else begin
            candidate_d  = candidate_q + CandWidth'(1);
            busy_phase_d = PhTest;
          end
        end
      end
      default: begin
        busy_phase_d = PhIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_phase_q  <= PhIdle;
      mode_q        <= 1'b0;
      candidate_q   <= '0;
      divisor_q     <= '0;
      found_count_q <= '0;
      pend_valid_q  <= 1'b0;
      trunc_q       <= 1'b0;
      target_q      <= '0;
    end else begin
      busy_phase_q  <= busy_phase_d;
      mode_q        <= mode_d;
      candidate_q   <= candidate_d;
      divisor_q     <= divisor_d;
      found_count_q <= found_count_d;
      pend_valid_q  <= pend_valid_d;
      trunc_q       <= trunc_d;
      target_q      <= target_d;
    end
  end

  always_ff @(posedge clk_i) begin
    upper_q      <= upper_d;
    dsq_q        <= dsq_d;
    pend_value_q <= pend_value_d;
    em_q         <= em_d;
  end

  tdpl_rem_unit #(
    .WIDTH (CandWidth)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (candidate_q),
    .divisor_i  (divisor_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  tdpl_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (em_q),
    .ready_o (out_ready),
    .res_o   (res_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   found_count_q <= CntW'(MAX_PRIMES))
    else $error("found count above limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   busy_phase_q == PhDiv |-> divisor_q >= CandWidth'(2) &&
                   dsq_q <= {1'b0, candidate_q})
    else $error("trial divisor out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   req_fire |=> busy_phase_q != PhIdle)
    else $error("request accepted without leaving idle");

endmodule

// ===== verif/trial_division_prime_lister_unit_tb.sv =====
`timescale 1ns / 1ps

module trial_division_prime_lister_unit_tb;

  localparam int unsigned ValueWidth     = tdpl_pkg::DefValueWidth;
  localparam int          MaxPrimes      = tdpl_pkg::DefMaxPrimes;
  localparam int          SinkHoldCycles = 3000;
  localparam int          RandomRequests = 70;
  localparam int          TailCycles     = 50;
  localparam longint      CycleLimit     = 20_000_000;

  logic clk_i;
  logic rst_ni;

  tdpl_req_if #(.VALUE_WIDTH(ValueWidth)) req_bus ();
  tdpl_res_if res_bus ();

  trial_division_prime_lister_unit #(
    .VALUE_WIDTH(ValueWidth),
    .MAX_PRIMES (MaxPrimes)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .res_o (res_bus)
  );

  tdpl_pkg::result_t expected_words[$];
  int      mismatch_count = 0;
  longint  cycle_count = 0;
  bit      idle_on = 1'b1;
  bit      hold_request = 1'b0;
  bit      sink_hold = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit is_prime_num(int n);
    if (n < 2) return 1'b0;
    for (int d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic tdpl_pkg::result_t make_word(int v, int idx, tdpl_pkg::status_e st,
                                                  bit lst);
    tdpl_pkg::result_t w;
    w.prime_value = v[tdpl_pkg::PrimeValueWidth-1:0];
    w.prime_index = idx[tdpl_pkg::IndexWidth-1:0];
    w.status      = st;
    w.last        = lst;
    return w;
  endfunction

  function automatic void predict_primes(bit m, int a, int b);
    tdpl_pkg::result_t words[$];
    int      lo;
    int      hi;
    int      n;
    int      cnt;
    bit      more;
    tdpl_pkg::status_e bad;
    cnt  = 0;
    more = 1'b0;
    if (m == 1'b0) begin
      if (a < 1) begin
        expected_words.push_back(make_word(0, 0, tdpl_pkg::StFirstBad, 1'b1));
        return;
      end
      n = 2;
      while (cnt < MaxPrimes && cnt < a) begin
        if (is_prime_num(n)) begin
          words.push_back(make_word(n, cnt, tdpl_pkg::StOk, 1'b0));
          cnt++;
        end
        n++;
      end
      more = (a > cnt);
    end else begin
      if (a < 1 || b < 1) begin
        bad = (a < 1 && b < 1) ? tdpl_pkg::StBothBad :
              ((a < 1) ? tdpl_pkg::StFirstBad : tdpl_pkg::StSecondBad);
        expected_words.push_back(make_word(0, 0, bad, 1'b1));
        return;
      end
      lo = (a <= b) ? a : b;
      hi = (a <= b) ? b : a;
      for (n = lo; n < hi; n++) begin
        if (is_prime_num(n)) begin
          if (cnt >= MaxPrimes) begin
            more = 1'b1;
            break;
          end
          words.push_back(make_word(n, cnt, tdpl_pkg::StOk, 1'b0));
          cnt++;
        end
      end
      if (cnt == 0) begin
        expected_words.push_back(make_word(0, 0, tdpl_pkg::StNone, 1'b1));
        return;
      end
    end
    words[cnt-1].last = 1'b1;
    if (more) words[cnt-1].status = tdpl_pkg::StTruncated;
    foreach (words[i]) expected_words.push_back(words[i]);
  endfunction

  task automatic send_request(input bit m, input int a, input int b);
    logic signed [ValueWidth-1:0] fa;
    logic signed [ValueWidth-1:0] fb;
    fa = a[ValueWidth-1:0];
    fb = b[ValueWidth-1:0];
    while (idle_on && $urandom_range(99) < 11) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.mode         <= m;
    req_bus.first_value  <= fa;
    req_bus.second_value <= fb;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    predict_primes(m, int'(fa), int'(fb));
  endtask

  task automatic drain_results();
    req_bus.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_bus.valid && res_bus.ready) begin
        if (expected_words.size() == 0) begin
          $display({"%0t: unexpected word, expected none actual ",
                    "value=%0d index=%0d status=%0d last=%0d"},
                   $time, res_bus.prime_value, res_bus.prime_index, res_bus.status,
                   res_bus.last);
          mismatch_count++;
        end else begin
          tdpl_pkg::result_t w;
          w = expected_words.pop_front();
          report_field("prime_value", 16'(w.prime_value), 16'(res_bus.prime_value));
          report_field("prime_index", 16'(w.prime_index), 16'(res_bus.prime_index));
          report_field("status", 16'(w.status), 16'(res_bus.status));
          report_field("last", 16'(w.last), 16'(res_bus.last));
        end
      end
      if (sink_hold) res_bus.ready <= 1'b0;
      else if (idle_on) res_bus.ready <= ($urandom_range(99) >= 11);
      else res_bus.ready <= 1'b1;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        sink_hold = 1'b1;
        repeat (SinkHoldCycles) @(posedge clk_i);
        sink_hold = 1'b0;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("%0t: timeout, %0d words still expected", $time, expected_words.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic test_arg_errors();
    send_request(1'b0, 0, 0);
    send_request(1'b0, -1, 32767);
    send_request(1'b0, -32768, -32768);
    send_request(1'b1, 0, 5);
    send_request(1'b1, 5, 0);
    send_request(1'b1, 0, 0);
    send_request(1'b1, -32768, 32767);
    send_request(1'b1, 32767, -32768);
    send_request(1'b1, -1, -32768);
  endtask

  task automatic test_small_lists();
    send_request(1'b0, 1, 0);
    send_request(1'b0, 2, -1);
    send_request(1'b0, 5, 12345);
    send_request(1'b1, 10, 20);
    send_request(1'b1, 20, 10);
    send_request(1'b1, 2, 3);
    send_request(1'b1, 1, 2);
    send_request(1'b1, 24, 28);
    send_request(1'b1, 32767, 32767);
    send_request(1'b1, 32767, 32760);
  endtask

  task automatic test_list_limits();
    send_request(1'b0, 63, 0);
    send_request(1'b0, 64, 0);
    send_request(1'b0, 32767, 0);
    send_request(1'b1, 1, 313);
    send_request(1'b1, 314, 1);
  endtask

  task automatic test_wide_prime();
    send_request(1'b1, 16384, 16412);
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_request(1'b0, int'($urandom_range(12, 4)), int'($urandom_range(65535)));
    end
    drain_results();
  endtask

  task automatic random_request();
    int sel;
    int m;
    int a;
    int b;
    int t;
    sel = $urandom_range(99);
    if (sel < 12) begin
      m = $urandom_range(1);
      a = -int'($urandom_range(32768));
      b = int'($urandom_range(65535)) - 32768;
      if (m == 1 && $urandom_range(1) == 1) begin
        t = a;
        a = b;
        b = t;
      end
    end else if (sel < 50) begin
      m = 0;
      a = ($urandom_range(9) == 0) ? int'($urandom_range(70, 21)) : int'($urandom_range(20, 1));
      b = int'($urandom_range(65535)) - 32768;
    end else begin
      m = 1;
      a = $urandom_range(200, 1);
      b = a + int'($urandom_range(30));
      if ($urandom_range(1) == 1) begin
        t = a;
        a = b;
        b = t;
      end
    end
    send_request(m[0], a, b);
  endtask

  task automatic test_random();
    for (int i = 0; i < RandomRequests; i++) begin
      idle_on = !(i >= 20 && i < 45);
      if (i == 55) drain_results();
      random_request();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_ni               <= 1'b0;
    req_bus.valid        <= 1'b0;
    req_bus.mode         <= 1'b0;
    req_bus.first_value  <= '0;
    req_bus.second_value <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_arg_errors();
    test_small_lists();
    test_list_limits();
    test_wide_prime();
    drain_results();
    test_backpressure();
    test_random();

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tdpl_pkg.sv
rtl/tdpl_if.sv
rtl/tdpl_rem_unit.sv
rtl/tdpl_out_reg.sv
rtl/trial_division_prime_lister_unit.sv
verif/trial_division_prime_lister_unit_tb.sv
